// ===== rtl/core/trht_pkg.sv =====
package trht_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int COORD_BITS_DEF  = 11;

	localparam int CMD_W   = 7;
	localparam int PCT_W   = 8;
	localparam int TYPE_W  = 3;
	localparam int INDEX_W = 4;
	localparam int COUNT_W = 5;
	localparam int QUO_W   = 7;

	localparam logic [QUO_W-1:0] PCT_SCALE = 7'd100;
	localparam logic [PCT_W-1:0] PCT_NONE  = 8'hFF;

	typedef enum logic [TYPE_W-1:0] {
		TYPE_CIRCLE = 3'd0,
		TYPE_RECT   = 3'd1,
		TYPE_PROG_X = 3'd2,
		TYPE_PROG_Y = 3'd3,
		TYPE_TEXT   = 3'd4
	} region_type_t;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic REG_ENTRY_COUNT     = 1'b0;
	localparam logic REG_DEFAULT_COMMAND = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} ctrl_state_t;

endpackage

// ===== rtl/core/trht_cell.sv =====
module trht_cell #(
	parameter int COORD_BITS = trht_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [trht_pkg::TYPE_W-1:0]   wr_type,
	input  logic [trht_pkg::CMD_W-1:0]    wr_cmd,
	input  logic signed [COORD_BITS-1:0]  wr_a,
	input  logic signed [COORD_BITS-1:0]  wr_b,
	input  logic signed [COORD_BITS-1:0]  wr_c,
	input  logic signed [COORD_BITS-1:0]  wr_d,
	input  logic                          active,
	input  logic                          tok_vld_i,
	input  logic signed [COORD_BITS-1:0]  tok_x_i,
	input  logic signed [COORD_BITS-1:0]  tok_y_i,
	input  logic [trht_pkg::CMD_W-1:0]    tok_hit_i,
	input  logic                          tok_pv_i,
	input  logic [COORD_BITS:0]           tok_off_i,
	input  logic [COORD_BITS:0]           tok_span_i,
	output logic                          tok_vld_o,
	output logic signed [COORD_BITS-1:0]  tok_x_o,
	output logic signed [COORD_BITS-1:0]  tok_y_o,
	output logic [trht_pkg::CMD_W-1:0]    tok_hit_o,
	output logic                          tok_pv_o,
	output logic [COORD_BITS:0]           tok_off_o,
	output logic [COORD_BITS:0]           tok_span_o
);

	localparam int DW = COORD_BITS + 1;
	localparam int SW = 2 * DW + 1;

	logic [trht_pkg::TYPE_W-1:0]  type_q;
	logic [trht_pkg::CMD_W-1:0]   cmd_q;
	logic signed [COORD_BITS-1:0] a_q, b_q, c_q, d_q;
	logic [2*COORD_BITS-1:0]      r2_q;

	logic                          vld_q, pv_q;
	logic signed [COORD_BITS-1:0]  x_q, y_q;
	logic [trht_pkg::CMD_W-1:0]    hit_q;
	logic [COORD_BITS:0]           off_q, span_q;

	logic signed [DW-1:0]     dx, dy, spx, spy;
	logic signed [2*DW-1:0]   dx2, dy2;
	logic [SW-1:0]            dsum;
	logic                     in_box, hit, prog;
	logic [COORD_BITS:0]      off, span;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			type_q <= wr_type;
			cmd_q  <= wr_cmd;
			a_q    <= wr_a;
			b_q    <= wr_b;
			c_q    <= wr_c;
			d_q    <= wr_d;
			r2_q   <= (2 * COORD_BITS)'(wr_c * wr_c);
		end
	end

	always_comb begin
		dx     = DW'(tok_x_i) - DW'(a_q);
		dy     = DW'(tok_y_i) - DW'(b_q);
		spx    = DW'(c_q) - DW'(a_q);
		spy    = DW'(d_q) - DW'(b_q);
		dx2    = dx * dx;
		dy2    = dy * dy;
		dsum   = SW'(unsigned'(dx2)) + SW'(unsigned'(dy2));
		in_box = (a_q < tok_x_i) && (c_q > tok_x_i) && (b_q < tok_y_i) && (d_q > tok_y_i);
		hit    = 1'b0;
		prog   = 1'b0;
		off    = unsigned'(dx);
		span   = unsigned'(spx);
		case (type_q)
			trht_pkg::TYPE_CIRCLE: hit = (c_q > 0) && (dsum < SW'(r2_q));
			trht_pkg::TYPE_RECT:   hit = in_box;
			trht_pkg::TYPE_PROG_X: begin
				hit  = in_box;
				prog = in_box;
			end
			trht_pkg::TYPE_PROG_Y: begin
				hit  = in_box;
				prog = in_box;
				off  = unsigned'(dy);
				span = unsigned'(spy);
			end
			default: hit = 1'b0;
		endcase
		hit  = hit && active;
		prog = prog && active;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tok_vld_i;
		end
	end

	always_ff @(posedge clk) begin
		x_q    <= tok_x_i;
		y_q    <= tok_y_i;
		hit_q  <= hit ? cmd_q : tok_hit_i;
		pv_q   <= prog | tok_pv_i;
		off_q  <= prog ? off : tok_off_i;
		span_q <= prog ? span : tok_span_i;
	end

	assign tok_vld_o  = vld_q;
	assign tok_x_o    = x_q;
	assign tok_y_o    = y_q;
	assign tok_hit_o  = hit_q;
	assign tok_pv_o   = pv_q;
	assign tok_off_o  = off_q;
	assign tok_span_o = span_q;

endmodule

// ===== rtl/core/trht_div.sv =====
module trht_div #(
	parameter int COORD_BITS = trht_pkg::COORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [COORD_BITS:0]        off,
	input  logic [COORD_BITS:0]        span,
	output logic                       done,
	output logic [trht_pkg::QUO_W-1:0] quo
);

	localparam int W = COORD_BITS + 1 + trht_pkg::QUO_W;

	logic                       busy_q, done_q;
	logic [2:0]                 k_q;
	logic [W-1:0]               rem_q, span_q, trial;
	logic [trht_pkg::QUO_W-1:0] quo_q;
	logic                       ge;

	assign trial = span_q << k_q;
	assign ge    = rem_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= 3'(trht_pkg::QUO_W - 1);
			end else if (busy_q) begin
				k_q <= k_q - 3'd1;
				if (k_q == 3'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= W'(off) * W'(trht_pkg::PCT_SCALE);
			span_q <= W'(span);
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - trial;
			end
			quo_q <= {quo_q[trht_pkg::QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/core/touch_region_hit_test_top.sv =====
// Path: a query travels through a chain of one cell per entry, then, when a progress bar
// is hit, through the divider, before the result is registered at the output.
// A new query or write is taken only in the idle state, once the last result is registered.
// Reset: arst_n clears control state and registers; table entries are undefined until written.
module touch_region_hit_test_top #(
	parameter int MAX_ENTRIES = trht_pkg::MAX_ENTRIES_DEF,
	parameter int COORD_BITS  = trht_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic                           cfg_index,
	input  logic [trht_pkg::CMD_W-1:0]     cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cmd,
	input  logic [trht_pkg::INDEX_W-1:0]   entry_index,
	input  logic [trht_pkg::TYPE_W-1:0]    entry_type,
	input  logic signed [trht_pkg::CMD_W-1:0] entry_command,
	input  logic signed [COORD_BITS-1:0]   left_or_center_x,
	input  logic signed [COORD_BITS-1:0]   top_or_center_y,
	input  logic signed [COORD_BITS-1:0]   right_or_radius,
	input  logic signed [COORD_BITS-1:0]   bottom_edge,
	input  logic signed [COORD_BITS-1:0]   touch_x,
	input  logic signed [COORD_BITS-1:0]   touch_y,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [trht_pkg::CMD_W-1:0] hit_command,
	output logic signed [trht_pkg::PCT_W-1:0] position_percent
);

	localparam int NW = ($clog2(MAX_ENTRIES + 1) > trht_pkg::COUNT_W) ?
		$clog2(MAX_ENTRIES + 1) : trht_pkg::COUNT_W;

	trht_pkg::ctrl_state_t state_q;

	logic [trht_pkg::COUNT_W-1:0] entry_count_q;
	logic [trht_pkg::CMD_W-1:0]   default_cmd_q;
	logic                         launch_q;
	logic signed [COORD_BITS-1:0] qx_q, qy_q;
	logic [trht_pkg::CMD_W-1:0]   res_cmd_q;
	logic [trht_pkg::PCT_W-1:0]   res_pct_q;
	logic                         out_valid_q;
	logic [trht_pkg::CMD_W-1:0]   out_cmd_q;
	logic [trht_pkg::PCT_W-1:0]   out_pct_q;

	logic accept, wr_item;

	logic                          ch_vld  [0:MAX_ENTRIES];
	logic signed [COORD_BITS-1:0]  ch_x    [0:MAX_ENTRIES];
	logic signed [COORD_BITS-1:0]  ch_y    [0:MAX_ENTRIES];
	logic [trht_pkg::CMD_W-1:0]    ch_hit  [0:MAX_ENTRIES];
	logic                          ch_pv   [0:MAX_ENTRIES];
	logic [COORD_BITS:0]           ch_off  [0:MAX_ENTRIES];
	logic [COORD_BITS:0]           ch_span [0:MAX_ENTRIES];

	logic                       div_start, div_done;
	logic [trht_pkg::QUO_W-1:0] div_quo;

	assign in_ready = (state_q == trht_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign wr_item  = accept && (cmd == trht_pkg::CMD_WRITE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			default_cmd_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				trht_pkg::REG_ENTRY_COUNT:     entry_count_q <= cfg_wdata[trht_pkg::COUNT_W-1:0];
				trht_pkg::REG_DEFAULT_COMMAND: default_cmd_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			qx_q <= touch_x;
			qy_q <= touch_y;
		end
	end

	assign ch_vld[0]  = launch_q;
	assign ch_x[0]    = qx_q;
	assign ch_y[0]    = qy_q;
	assign ch_hit[0]  = default_cmd_q;
	assign ch_pv[0]   = 1'b0;
	assign ch_off[0]  = '0;
	assign ch_span[0] = '0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic wr_sel, active;
		assign wr_sel = wr_item && (int'(entry_index) == i);
		assign active = NW'(i) < NW'(entry_count_q);
		trht_cell #(.COORD_BITS(COORD_BITS)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.wr_en      (wr_sel),
			.wr_type    (entry_type),
			.wr_cmd     (entry_command),
			.wr_a       (left_or_center_x),
			.wr_b       (top_or_center_y),
			.wr_c       (right_or_radius),
			.wr_d       (bottom_edge),
			.active     (active),
			.tok_vld_i  (ch_vld[i]),
			.tok_x_i    (ch_x[i]),
			.tok_y_i    (ch_y[i]),
			.tok_hit_i  (ch_hit[i]),
			.tok_pv_i   (ch_pv[i]),
			.tok_off_i  (ch_off[i]),
			.tok_span_i (ch_span[i]),
			.tok_vld_o  (ch_vld[i+1]),
			.tok_x_o    (ch_x[i+1]),
			.tok_y_o    (ch_y[i+1]),
			.tok_hit_o  (ch_hit[i+1]),
			.tok_pv_o   (ch_pv[i+1]),
			.tok_off_o  (ch_off[i+1]),
			.tok_span_o (ch_span[i+1])
		);
	end

	assign div_start = (state_q == trht_pkg::ST_SCAN) && ch_vld[MAX_ENTRIES] && ch_pv[MAX_ENTRIES];

	trht_div #(.COORD_BITS(COORD_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.off    (ch_off[MAX_ENTRIES]),
		.span   (ch_span[MAX_ENTRIES]),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= trht_pkg::ST_IDLE;
			launch_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			launch_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				trht_pkg::ST_IDLE: begin
					if (accept && (cmd == trht_pkg::CMD_QUERY)) begin
						launch_q <= 1'b1;
						state_q  <= trht_pkg::ST_SCAN;
					end
				end
				trht_pkg::ST_SCAN: begin
					if (ch_vld[MAX_ENTRIES]) begin
						state_q <= ch_pv[MAX_ENTRIES] ? trht_pkg::ST_DIV : trht_pkg::ST_DONE;
					end
				end
				trht_pkg::ST_DIV: begin
					if (div_done) begin
						state_q <= trht_pkg::ST_DONE;
					end
				end
				trht_pkg::ST_DONE: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						state_q     <= trht_pkg::ST_IDLE;
					end
				end
				default: state_q <= trht_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == trht_pkg::ST_SCAN && ch_vld[MAX_ENTRIES]) begin
			res_cmd_q <= ch_hit[MAX_ENTRIES];
			res_pct_q <= trht_pkg::PCT_NONE;
		end
		if (state_q == trht_pkg::ST_DIV && div_done) begin
			res_pct_q <= {1'b0, div_quo};
		end
		if (state_q == trht_pkg::ST_DONE && !out_valid_q) begin
			out_cmd_q <= res_cmd_q;
			out_pct_q <= res_pct_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign hit_command      = out_cmd_q;
	assign position_percent = out_pct_q;

endmodule

// ===== bench/tb_touch_region_hit_test_top.sv =====
`timescale 1ns / 100ps

module tb_touch_region_hit_test_top;

	localparam int MAXN = trht_pkg::MAX_ENTRIES_DEF;
	localparam int CB = trht_pkg::COORD_BITS_DEF;
	localparam int CW = trht_pkg::CMD_W;
	localparam int PW = trht_pkg::PCT_W;
	localparam int TW = trht_pkg::TYPE_W;
	localparam int IW = trht_pkg::INDEX_W;
	localparam int NCW = trht_pkg::COUNT_W;
	localparam int LAT = MAXN + 11;
	localparam longint LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_index = trht_pkg::REG_ENTRY_COUNT;
	logic [CW-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = trht_pkg::CMD_WRITE;
	logic [IW-1:0] entry_index = '0;
	logic [TW-1:0] entry_type = '0;
	logic signed [CW-1:0] entry_command = '0;
	logic signed [CB-1:0] left_or_center_x = '0, top_or_center_y = '0;
	logic signed [CB-1:0] right_or_radius = '0, bottom_edge = '0;
	logic signed [CB-1:0] touch_x = '0, touch_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [CW-1:0] hit_command;
	logic signed [PW-1:0] position_percent;

	touch_region_hit_test_top DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef struct {
		logic [TW-1:0] kind;
		logic signed [CW-1:0] code;
		int a, b, c, d;
	} region_t;

	typedef struct {
		logic signed [CW-1:0] code;
		logic signed [PW-1:0] pct;
	} hit_t;

	region_t regions [MAXN];
	logic [NCW-1:0] scan_count = '0;
	logic signed [CW-1:0] fallback_code = '0;
	hit_t pending_hits[$];
	int mismatches = 0, results_seen = 0, queries_sent = 0, writes_sent = 0;
	longint cycles = 0;
	bit calm = 1'b0;

	function automatic int span_pct(int off, int span);
		int p;
		if (span <= 0)
			return 99;
		p = (100 * off) / span;
		return (p >= 100) ? 99 : p;
	endfunction

	function automatic hit_t resolve_touch(int x, int y);
		hit_t h;
		int n;
		int dx, dy;
		h.code = fallback_code;
		h.pct = '1;
		n = (int'(scan_count) > MAXN) ? MAXN : int'(scan_count);
		for (int i = 0; i < n; i++) begin
			region_t r;
			bit ins;
			r = regions[i];
			ins = r.a < x && r.c > x && r.b < y && r.d > y;
			case (r.kind)
				trht_pkg::TYPE_CIRCLE: begin
					dx = x - r.a;
					dy = y - r.b;
					if (r.c > 0 && dx * dx + dy * dy < r.c * r.c)
						h.code = r.code;
				end
				trht_pkg::TYPE_RECT: if (ins) h.code = r.code;
				trht_pkg::TYPE_PROG_X: if (ins) begin
					h.code = r.code;
					h.pct = PW'(span_pct(x - r.a, r.c - r.a));
				end
				trht_pkg::TYPE_PROG_Y: if (ins) begin
					h.code = r.code;
					h.pct = PW'(span_pct(y - r.b, r.d - r.b));
				end
				default: ;
			endcase
		end
		return h;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 11);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			hit_t e;
			results_seen++;
			if (pending_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result %0d/%0d", hit_command, position_percent);
			end else begin
				e = pending_hits.pop_front();
				if (e.code !== hit_command || e.pct !== position_percent) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result %0d: expected %0d/%0d, got %0d/%0d",
							results_seen, e.code, e.pct, hit_command, position_percent);
				end
			end
		end
	end

	task automatic send_item(logic c, int idx, int kind, int code, int a, int b, int cc,
			int d, int x, int y);
		region_t r;
		while (!calm && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		r.kind = TW'(kind);
		r.code = CW'(code);
		r.a = $signed(CB'(a));
		r.b = $signed(CB'(b));
		r.c = $signed(CB'(cc));
		r.d = $signed(CB'(d));
		cmd <= c;
		entry_index <= IW'(idx);
		entry_type <= TW'(kind);
		entry_command <= CW'(code);
		left_or_center_x <= CB'(a);
		top_or_center_y <= CB'(b);
		right_or_radius <= CB'(cc);
		bottom_edge <= CB'(d);
		touch_x <= CB'(x);
		touch_y <= CB'(y);
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (c == trht_pkg::CMD_WRITE) begin
			regions[idx] = r;
			writes_sent++;
		end else begin
			pending_hits.push_back(resolve_touch($signed(CB'(x)), $signed(CB'(y))));
			queries_sent++;
		end
		@(negedge clk);
	endtask

	task automatic write_region(int idx, int kind, int code, int a, int b, int c, int d);
		send_item(trht_pkg::CMD_WRITE, idx, kind, code, a, b, c, d, $urandom, $urandom);
	endtask

	task automatic query(int x, int y);
		send_item(trht_pkg::CMD_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, x, y);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_hits.size() != 0)
			@(negedge clk);
		repeat (LAT + 2) @(negedge clk);
	endtask

	task automatic set_reg(logic idx, int v);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CW'(v);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == trht_pkg::REG_ENTRY_COUNT)
			scan_count = NCW'(v);
		else
			fallback_code = CW'(v);
	endtask

	function automatic int rc();
		return $signed(CB'($urandom));
	endfunction

	task automatic test_directed();
		set_reg(trht_pkg::REG_DEFAULT_COMMAND, -1);
		set_reg(trht_pkg::REG_ENTRY_COUNT, 0);
		query(0, 0);
		write_region(0, trht_pkg::TYPE_CIRCLE, 5, 0, 0, 10, 0);
		write_region(1, trht_pkg::TYPE_PROG_X, 62, -100, -10, 100, 10);
		write_region(2, trht_pkg::TYPE_RECT, 7, -1024, -1024, 1023, 1023);
		write_region(3, trht_pkg::TYPE_PROG_Y, 9, -5, -1024, 5, 1023);
		write_region(4, trht_pkg::TYPE_TEXT, 3, -1024, -1024, 1023, 1023);
		write_region(5, 6, 4, -1024, -1024, 1023, 1023);
		write_region(6, trht_pkg::TYPE_CIRCLE, 8, 0, 0, -5, 0);
		for (int i = 7; i < MAXN; i++)
			write_region(i, trht_pkg::TYPE_RECT, i, 1023, 1023, -1024, -1024);
		set_reg(trht_pkg::REG_ENTRY_COUNT, 2);
		query(6, 8);
		query(10, 0);
		query(99, 0);
		set_reg(trht_pkg::REG_ENTRY_COUNT, 31);
		query(50, 0);
		query(0, 1022);
		query(-1024, 1023);
		set_reg(trht_pkg::REG_DEFAULT_COMMAND, 62);
		set_reg(trht_pkg::REG_ENTRY_COUNT, 16);
		query(1023, -1024);
		query(0, 0);
	endtask

	task automatic test_random(int n);
		int kind, a, b, c, d;
		for (int k = 0; k < n; k++) begin
			calm = (k > n / 2 && k < n / 2 + 150);
			if (k % 200 == 0) begin
				set_reg(trht_pkg::REG_ENTRY_COUNT, $urandom_range(31));
				set_reg(trht_pkg::REG_DEFAULT_COMMAND, $urandom_range(63) - 1);
			end
			if ($urandom_range(99) < 35) begin
				kind = $urandom_range(99) < 90 ? $urandom_range(4) : $urandom_range(7);
				a = rc();
				b = rc();
				c = rc();
				d = rc();
				if ($urandom_range(3) != 0) begin
					a = $urandom_range(800) - 512;
					b = $urandom_range(800) - 512;
					c = (kind == trht_pkg::TYPE_CIRCLE) ? $urandom_range(300) - 20
						: a + $urandom_range(500);
					d = b + $urandom_range(500);
				end
				write_region($urandom_range(MAXN - 1), kind,
					$signed(CW'($urandom)), a, b, c, d);
			end else if ($urandom_range(3) == 0) begin
				query(rc(), rc());
			end else begin
				query($urandom_range(1100) - 550, $urandom_range(1100) - 550);
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int i = 0; i < MAXN; i++)
			write_region(i, trht_pkg::TYPE_TEXT, -1, 0, 0, 0, 0);
		test_directed();
		test_random(1400);
		drain();
		$display("Sent %0d writes and %0d queries, checked %0d results",
			writes_sent, queries_sent, results_seen);
		if (mismatches == 0 && pending_hits.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
